@@ rtl/core/hfr_pkg.sv @@
// Package for the forward recursion core: types, codes and constants.
// Used by the RAM wrapper users, the double-precision unit and the top level.
`default_nettype none

package hfr_pkg;

    localparam int NUM_STATES_DEF  = 4;
    localparam int NUM_SYMBOLS_DEF = 4;

    localparam logic [63:0] DBL_ZERO = 64'h0000_0000_0000_0000;
    localparam logic [63:0] DBL_DNAN = 64'hFFF8_0000_0000_0000;
    localparam logic [15:0] POS_MAX  = 16'hFFFF;

    typedef enum logic [1:0] {
        ACT_INIT = 2'd0,
        ACT_EMIT = 2'd1,
        ACT_TERM = 2'd2
    } act_t;

    typedef enum logic {
        FOP_MUL = 1'b0,
        FOP_ADD = 1'b1
    } fpu_op_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MULT,
        F_ALIGN,
        F_ADDSUB,
        F_NORM,
        F_ROUND,
        F_DONE
    } fpu_state_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_EXEC,
        T_RD,
        T_MUL1,
        T_MUL2,
        T_ADD,
        T_OUT
    } top_state_t;

    typedef struct packed {
        logic        start;
        fpu_op_t     op;
        logic [63:0] a;
        logic [63:0] b;
    } fpu_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } fpu_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/hfr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hfr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/hfr_fpu.sv @@
// Sequential IEEE double unit: multiply (four 27x27 partial products) and add,
// round to nearest even with subnormals. Depends on hfr_pkg.
`default_nettype none

module hfr_fpu
    import hfr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire fpu_req_t req,
    output fpu_rsp_t      rsp
);

    fpu_state_t st_reg, st_next;

    logic [2:0]         k_reg;
    logic [52:0]        ma_reg, mb_reg;
    logic [10:0]        ea_reg, eb_reg;
    logic               sa_reg, sb_reg, s_reg;
    logic [109:0]       r_reg, y_reg;
    logic signed [13:0] be_reg;
    logic [53:0]        pp_reg;
    logic [63:0]        res_reg;

    // unpack
    logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [10:0] ea_raw, eb_raw, eea, eeb;
    logic [52:0] ma, mb;
    logic        spec;
    logic [63:0] spec_val;

    always_comb
    begin
        sa     = req.a[63];
        sb     = req.b[63];
        ea_raw = req.a[62:52];
        eb_raw = req.b[62:52];
        ma     = {ea_raw != 11'd0, req.a[51:0]};
        mb     = {eb_raw != 11'd0, req.b[51:0]};
        eea    = (ea_raw == 11'd0) ? 11'd1 : ea_raw;
        eeb    = (eb_raw == 11'd0) ? 11'd1 : eb_raw;
        a_nan  = (ea_raw == 11'h7FF) && (req.a[51:0] != 52'd0);
        b_nan  = (eb_raw == 11'h7FF) && (req.b[51:0] != 52'd0);
        a_inf  = (ea_raw == 11'h7FF) && (req.a[51:0] == 52'd0);
        b_inf  = (eb_raw == 11'h7FF) && (req.b[51:0] == 52'd0);
        a_zero = (ea_raw == 11'd0) && (req.a[51:0] == 52'd0);
        b_zero = (eb_raw == 11'd0) && (req.b[51:0] == 52'd0);
        spec     = 1'b1;
        spec_val = DBL_DNAN;
        if (a_nan)
        begin
            spec_val = req.a | 64'h0008_0000_0000_0000;
        end
        else if (b_nan)
        begin
            spec_val = req.b | 64'h0008_0000_0000_0000;
        end
        else if (req.op == FOP_MUL)
        begin
            if ((a_inf && b_zero) || (a_zero && b_inf))
            begin
                spec_val = DBL_DNAN;
            end
            else if (a_inf || b_inf)
            begin
                spec_val = {sa ^ sb, 11'h7FF, 52'd0};
            end
            else
            begin
                spec = 1'b0;
            end
        end
        else
        begin
            if (a_inf && b_inf && (sa != sb))
            begin
                spec_val = DBL_DNAN;
            end
            else if (a_inf)
            begin
                spec_val = req.a;
            end
            else if (b_inf)
            begin
                spec_val = req.b;
            end
            else
            begin
                spec = 1'b0;
            end
        end
    end

    // alignment
    logic         a_big;
    logic [52:0]  x_m, y_m;
    logic [10:0]  x_e, y_e, d;
    logic [109:0] y_w, y_sh, y_mask;

    always_comb
    begin
        a_big  = (ea_reg > eb_reg) || ((ea_reg == eb_reg) && (ma_reg >= mb_reg));
        x_m    = a_big ? ma_reg : mb_reg;
        y_m    = a_big ? mb_reg : ma_reg;
        x_e    = a_big ? ea_reg : eb_reg;
        y_e    = a_big ? eb_reg : ea_reg;
        d      = x_e - y_e;
        y_w    = {1'b0, y_m, 56'd0};
        y_mask = (110'd1 << d) - 110'd1;
        if (d >= 11'd110)
        begin
            y_sh = {109'd0, |y_m};
        end
        else
        begin
            y_sh = (y_w >> d) | {109'd0, |(y_w & y_mask)};
        end
    end

    // add or subtract
    logic         sub;
    logic [109:0] sum;

    assign sub = sa_reg != sb_reg;
    assign sum = sub ? (r_reg - y_reg) : (r_reg + y_reg);

    // multiply step
    logic [26:0] a_op, b_op;
    logic [6:0]  pp_sh;

    always_comb
    begin
        a_op = k_reg[1] ? {1'b0, ma_reg[52:27]} : ma_reg[26:0];
        b_op = k_reg[0] ? {1'b0, mb_reg[52:27]} : mb_reg[26:0];
        case (k_reg)
            3'd1:    pp_sh = 7'd4;
            3'd4:    pp_sh = 7'd58;
            default: pp_sh = 7'd31;
        endcase
    end

    // normalize decisions
    logic r_zero, do_left, do_right, big_left, big_right;

    always_comb
    begin
        r_zero    = r_reg == 110'd0;
        do_left   = !r_zero && !r_reg[109] && (be_reg > 14'sd1);
        do_right  = !r_zero && !do_left && (be_reg < 14'sd1);
        big_left  = (r_reg[109:94] == 16'd0) && (be_reg > 14'sd16);
        big_right = be_reg < -14'sd14;
    end

    // round and pack
    logic [53:0]        m54;
    logic [52:0]        mant_f;
    logic signed [13:0] be_f;
    logic               up;
    logic [63:0]        packed_val;

    always_comb
    begin
        up     = r_reg[56] && ((|r_reg[55:0]) || r_reg[57]);
        m54    = {1'b0, r_reg[109:57]} + {53'd0, up};
        mant_f = m54[53] ? m54[53:1] : m54[52:0];
        be_f   = be_reg + (m54[53] ? 14'sd1 : 14'sd0);
        if (be_f >= 14'sd2047)
        begin
            packed_val = {s_reg, 11'h7FF, 52'd0};
        end
        else
        begin
            packed_val = {s_reg, mant_f[52] ? be_f[10:0] : 11'd0, mant_f[51:0]};
        end
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            F_IDLE, F_DONE:
            begin
                st_next = F_IDLE;
                if (req.start)
                begin
                    if (spec)
                    begin
                        st_next = F_DONE;
                    end
                    else if (req.op == FOP_MUL)
                    begin
                        st_next = F_MULT;
                    end
                    else
                    begin
                        st_next = F_ALIGN;
                    end
                end
            end
            F_MULT:   st_next = (k_reg == 3'd4) ? F_NORM : F_MULT;
            F_ALIGN:  st_next = F_ADDSUB;
            F_ADDSUB: st_next = F_NORM;
            F_NORM:   st_next = (do_left || do_right) ? F_NORM : F_ROUND;
            F_ROUND:  st_next = F_DONE;
            default:  st_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        rsp.done   = st_reg == F_DONE;
        rsp.result = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= F_IDLE;
            k_reg  <= 3'd0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == F_MULT)
            begin
                k_reg <= k_reg + 3'd1;
            end
            else
            begin
                k_reg <= 3'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            F_IDLE, F_DONE:
            begin
                if (req.start)
                begin
                    res_reg <= spec_val;
                    ma_reg  <= ma;
                    mb_reg  <= mb;
                    ea_reg  <= eea;
                    eb_reg  <= eeb;
                    sa_reg  <= sa;
                    sb_reg  <= sb;
                    s_reg   <= sa ^ sb;
                    r_reg   <= 110'd0;
                    be_reg  <= $signed({3'd0, eea}) + $signed({3'd0, eeb}) - 14'sd1022;
                end
            end
            F_MULT:
            begin
                pp_reg <= a_op * b_op;
                if (k_reg != 3'd0)
                begin
                    r_reg <= r_reg + ({56'd0, pp_reg} << pp_sh);
                end
            end
            F_ALIGN:
            begin
                r_reg  <= {1'b0, x_m, 56'd0};
                y_reg  <= y_sh;
                s_reg  <= a_big ? sa_reg : sb_reg;
                be_reg <= $signed({3'd0, x_e}) + 14'sd1;
            end
            F_ADDSUB:
            begin
                r_reg <= sum;
                if (sum == 110'd0)
                begin
                    s_reg <= sub ? 1'b0 : sa_reg;
                end
            end
            F_NORM:
            begin
                if (do_left)
                begin
                    if (big_left)
                    begin
                        r_reg  <= r_reg << 16;
                        be_reg <= be_reg - 14'sd16;
                    end
                    else
                    begin
                        r_reg  <= r_reg << 1;
                        be_reg <= be_reg - 14'sd1;
                    end
                end
                else if (do_right)
                begin
                    if (big_right)
                    begin
                        r_reg  <= (r_reg >> 16) | {109'd0, |r_reg[15:0]};
                        be_reg <= be_reg + 14'sd16;
                    end
                    else
                    begin
                        r_reg  <= (r_reg >> 1) | {109'd0, r_reg[0]};
                        be_reg <= be_reg + 14'sd1;
                    end
                end
            end
            F_ROUND:
            begin
                res_reg <= packed_val;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/hmm_forward_recursion_core.sv @@
// Forward recursion core: one item at a time. A load item is accepted, decoded
// and written, an init item waiting for a free output slot; a term item is accepted,
// decoded and read, then takes two multiplies and one add in the shared double unit,
// and the term that emits an entry also writes it out; subnormals take longer.
// A new item is taken only once the last is through. Reset clears control, position and
// bank select; the alpha and emission RAMs hold no defined value until written.
// Depends on hfr_pkg, hfr_ram and hfr_fpu.
`default_nettype none

module hmm_forward_recursion_core
    import hfr_pkg::*;
#(
    parameter int NUM_STATES  = NUM_STATES_DEF,
    parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [1:0]  prev_state,
    input  wire logic [1:0]  next_state,
    input  wire logic [1:0]  symbol,
    input  wire logic [63:0] value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       state_index,
    output logic [15:0]      position,
    output logic [63:0]      forward_value,
    output logic             last_of_position
);

    localparam int SW     = $clog2(NUM_STATES);
    localparam int ADEPTH = 2 << SW;
    localparam int AW     = SW + 1;
    localparam int EDEPTH = NUM_SYMBOLS * NUM_STATES;
    localparam int EW     = $clog2(EDEPTH);

    top_state_t st_reg, st_next;

    logic [1:0]  act_reg, ps_reg, ns_reg, sym_reg;
    logic [63:0] val_reg, emit_reg, acc_reg;
    logic        bank_reg;
    logic [15:0] pos_reg;
    logic        out_valid_reg;
    logic [1:0]  out_st_reg;
    logic [15:0] out_pos_reg;
    logic [63:0] out_val_reg;
    logic        out_last_reg;

    logic        ps_ok, ns_ok, sym_ok, ps_last, ns_last, slot_free;
    logic        init_load, term_load;
    logic [15:0] pos_inc;

    logic          a_we, e_we;
    logic [AW-1:0] a_waddr, a_raddr;
    logic [EW-1:0] e_addr;
    logic [63:0]   a_wdata, a_rdata, e_rdata;

    fpu_req_t fpu_req;
    fpu_rsp_t fpu_rsp;

    always_comb
    begin
        ps_ok     = 32'(ps_reg) < 32'(NUM_STATES);
        ns_ok     = 32'(ns_reg) < 32'(NUM_STATES);
        sym_ok    = 32'(sym_reg) < 32'(NUM_SYMBOLS);
        ps_last   = 32'(ps_reg) == 32'(NUM_STATES - 1);
        ns_last   = 32'(ns_reg) == 32'(NUM_STATES - 1);
        slot_free = !out_valid_reg || out_ready;
        init_load = (st_reg == T_EXEC) && (act_reg == ACT_INIT) && ns_ok && slot_free;
        term_load = (st_reg == T_OUT) && slot_free;
        pos_inc   = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 16'd1;
        e_addr    = EW'(EW'(sym_reg) * EW'(NUM_STATES) + EW'(ps_reg));
        a_raddr   = {bank_reg, SW'(ps_reg)};
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            T_IDLE:
            begin
                if (in_valid)
                begin
                    st_next = T_EXEC;
                end
            end
            T_EXEC:
            begin
                case (act_reg)
                    ACT_INIT:
                    begin
                        if (!ns_ok || slot_free)
                        begin
                            st_next = T_IDLE;
                        end
                    end
                    ACT_TERM:
                    begin
                        st_next = (ps_ok && ns_ok && sym_ok) ? T_RD : T_IDLE;
                    end
                    default: st_next = T_IDLE;
                endcase
            end
            T_RD:    st_next = T_MUL1;
            T_MUL1:  st_next = fpu_rsp.done ? T_MUL2 : T_MUL1;
            T_MUL2:  st_next = fpu_rsp.done ? T_ADD : T_MUL2;
            T_ADD:
            begin
                if (fpu_rsp.done)
                begin
                    st_next = ps_last ? T_OUT : T_IDLE;
                end
            end
            T_OUT:   st_next = slot_free ? T_IDLE : T_OUT;
            default: st_next = T_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = st_reg == T_IDLE;
        a_we          = 1'b0;
        a_waddr       = {bank_reg, SW'(ns_reg)};
        a_wdata       = val_reg;
        e_we          = 1'b0;
        fpu_req.start = 1'b0;
        fpu_req.op    = FOP_MUL;
        fpu_req.a     = a_rdata;
        fpu_req.b     = val_reg;
        case (st_reg)
            T_EXEC:
            begin
                a_we = (act_reg == ACT_INIT) && ns_ok && slot_free;
                e_we = (act_reg == ACT_EMIT) && ps_ok && sym_ok;
            end
            T_RD:
            begin
                fpu_req.start = 1'b1;
            end
            T_MUL1:
            begin
                fpu_req.start = fpu_rsp.done;
                fpu_req.a     = fpu_rsp.result;
                fpu_req.b     = emit_reg;
            end
            T_MUL2:
            begin
                fpu_req.start = fpu_rsp.done;
                fpu_req.op    = FOP_ADD;
                fpu_req.a     = (ps_reg == 2'd0) ? DBL_ZERO : acc_reg;
                fpu_req.b     = fpu_rsp.result;
            end
            T_OUT:
            begin
                a_we    = slot_free;
                a_waddr = {~bank_reg, SW'(ns_reg)};
                a_wdata = acc_reg;
            end
            default:
            begin
            end
        endcase
    end

    hfr_ram #(
        .WIDTH (64),
        .DEPTH (ADEPTH)
    ) u_alpha_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    hfr_ram #(
        .WIDTH (64),
        .DEPTH (EDEPTH)
    ) u_emit_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_addr),
        .wdata (val_reg),
        .raddr (e_addr),
        .rdata (e_rdata)
    );

    hfr_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fpu_req),
        .rsp   (fpu_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= T_IDLE;
            bank_reg      <= 1'b0;
            pos_reg       <= 16'd0;
            acc_reg       <= DBL_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (init_load || term_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (st_reg)
                T_EXEC:
                begin
                    if (init_load)
                    begin
                        pos_reg <= 16'd0;
                        acc_reg <= DBL_ZERO;
                    end
                end
                T_ADD:
                begin
                    if (fpu_rsp.done)
                    begin
                        acc_reg <= fpu_rsp.result;
                    end
                end
                T_OUT:
                begin
                    if (slot_free && ns_last)
                    begin
                        bank_reg <= ~bank_reg;
                        pos_reg  <= pos_inc;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            act_reg <= action;
            ps_reg  <= prev_state;
            ns_reg  <= next_state;
            sym_reg <= symbol;
            val_reg <= value;
        end
        if (st_reg == T_RD)
        begin
            emit_reg <= e_rdata;
        end
        if (init_load)
        begin
            out_st_reg   <= ns_reg;
            out_pos_reg  <= 16'd0;
            out_val_reg  <= val_reg;
            out_last_reg <= ns_last;
        end
        if (term_load)
        begin
            out_st_reg   <= ns_reg;
            out_pos_reg  <= pos_inc;
            out_val_reg  <= acc_reg;
            out_last_reg <= ns_last;
        end
    end

    assign out_valid        = out_valid_reg;
    assign state_index      = out_st_reg;
    assign position         = out_pos_reg;
    assign forward_value    = out_val_reg;
    assign last_of_position = out_last_reg;

endmodule

`default_nettype wire
